FILE: rtl/slab_bitmap_allocator_defines.svh
// Assertion macros shared by the slab allocator checker
`ifndef SLAB_BITMAP_ALLOCATOR_DEFINES_SVH
`define SLAB_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, masked during reset
`define SBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define SBA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// holds in the cycle after reset is seen
`define SBA_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

FILE: rtl/sba_pkg.sv
// Shared types, constants and class tables of the slab allocator
package sba_pkg;

   localparam int MAX_PAGES_DEF    = 16;
   localparam int EXPAND_PAGES_DEF = 8;
   localparam int PAGE_BYTES       = 4096;
   localparam int PAGE_SHIFT       = 12;
   localparam int ADDR_W           = 48;
   localparam int SIZE_W           = 32;
   localparam int STATUS_W         = 4;
   localparam int CLASS_W          = 3;
   localparam int WORD_BITS        = 64;
   localparam int WORDS_PER_PAGE   = 4;
   localparam int PAGEQ_W          = 16;
   localparam int SLOT_W           = 8;
   localparam logic [SIZE_W-1:0] MAX_OBJ_BYTES = 32'd2048;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 4'd0,
      ST_ZERO_SIZE   = 4'd1,
      ST_TOO_LARGE   = 4'd2,
      ST_NO_PAGES    = 4'd3,
      ST_UNKNOWN     = 4'd4,
      ST_UNDERFLOW   = 4'd5,
      ST_MISALIGNED  = 4'd6,
      ST_RANGE       = 4'd7,
      ST_DOUBLE_FREE = 4'd8,
      ST_NULL        = 4'd9
   } status_type;

   // classified transaction handed from front to engine
   typedef struct packed {
      logic                   is_free;
      status_type             status;
      logic [CLASS_W-1:0]     cls;
      logic [PAGEQ_W-1:0]     page_q;
      logic [PAGE_SHIFT-1:0]  offset;
   } cmd_type;

   // per-page metadata word
   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [SLOT_W-1:0]  used;
   } meta_type;

   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] c;
      c = '0;
      for (int i = 7; i >= 0; i--) begin
         if (size <= (32'd16 << i)) c = CLASS_W'(i);
      end
      return c;
   endfunction

   function automatic logic [SLOT_W-1:0] class_cap(input logic [CLASS_W-1:0] c);
      logic [SLOT_W-1:0] cap;
      case (c)
         3'd0: cap = 8'd252;
         3'd1: cap = 8'd126;
         3'd2: cap = 8'd63;
         3'd3: cap = 8'd31;
         3'd4: cap = 8'd15;
         3'd5: cap = 8'd7;
         3'd6: cap = 8'd3;
         default: cap = 8'd1;
      endcase
      return cap;
   endfunction

   // header plus bitmap words
   function automatic logic [PAGE_SHIFT-1:0] obj_offset(input logic [CLASS_W-1:0] c);
      logic [PAGE_SHIFT-1:0] off;
      case (c)
         3'd0: off = 12'd56;
         3'd1: off = 12'd40;
         default: off = 12'd32;
      endcase
      return off;
   endfunction

   // bits of bitmap word w that map onto real slots
   function automatic logic [WORD_BITS-1:0] valid_mask(input logic [CLASS_W-1:0] c,
                                                       input logic [1:0] w);
      logic [6:0] nbits;
      logic [WORD_BITS-1:0] m;
      case (c)
         3'd0: nbits = (w == 2'd3) ? 7'd60 : 7'd64;
         3'd1: nbits = (w == 2'd0) ? 7'd64 : 7'd62;
         default: nbits = 7'(class_cap(c));
      endcase
      if (nbits == 7'd64) m = '1;
      else m = (64'd1 << nbits[5:0]) - 64'd1;
      return m;
   endfunction

   function automatic logic [5:0] lowest_zero(input logic [WORD_BITS-1:0] word);
      logic [5:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) pos = 6'(i);
      end
      return pos;
   endfunction

endpackage

FILE: rtl/sba_if.sv
// Request and response channel interfaces of the slab allocator
interface sba_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] request_size;
   logic [47:0] free_address;
   modport source (output valid, mode, request_size, free_address, input ready);
   modport sink   (input valid, mode, request_size, free_address, output ready);
endinterface

interface sba_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [47:0] object_address;
   logic [2:0]  size_class;
   modport source (output valid, status, object_address, size_class, input ready);
   modport sink   (input valid, status, object_address, size_class, output ready);
endinterface

FILE: rtl/sba_ram.sv
// Generic single-write, single-read RAM with registered read data
module sba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/sba_fifo.sv
// Small FIFO between the classifier and the engine
module sba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end
endmodule

FILE: rtl/sba_front.sv
// Request classifier: size class, early errors and slab page offset
module sba_front #(
   parameter int MAX_PAGES    = sba_pkg::MAX_PAGES_DEF,
   parameter int EXPAND_PAGES = sba_pkg::EXPAND_PAGES_DEF
) (
   sba_req_if.sink                  req,
   input  logic [sba_pkg::ADDR_W-1:0] page0_base,
   output sba_pkg::cmd_type         cmd,
   output logic                     cmd_push,
   input  logic                     cmd_full
);
   import sba_pkg::*;

   localparam logic [ADDR_W-1:0] SLAB_SPAN =
      ADDR_W'(MAX_PAGES * EXPAND_PAGES * PAGE_BYTES);

   logic [ADDR_W-1:0] page_dist;

   assign req.ready = !cmd_full;
   assign cmd_push  = req.valid && !cmd_full;

   // distance of the address's page from the first slab page, modulo 2^48
   assign page_dist = {req.free_address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} - page0_base;

   always_comb begin
      cmd         = '0;
      cmd.is_free = req.mode;
      cmd.offset  = req.free_address[PAGE_SHIFT-1:0];
      cmd.page_q  = page_dist[PAGE_SHIFT +: PAGEQ_W];
      if (!req.mode) begin
         if (req.request_size == '0) cmd.status = ST_ZERO_SIZE;
         else if (req.request_size > MAX_OBJ_BYTES) cmd.status = ST_TOO_LARGE;
         else begin
            cmd.status = ST_OK;
            cmd.cls    = class_of(req.request_size);
         end
      end else if (req.free_address == '0) begin
         cmd.status = ST_NULL;
      end else if (page_dist >= SLAB_SPAN) begin
         cmd.status = ST_UNKNOWN;
      end else begin
         cmd.status = ST_OK;
      end
   end
endmodule

FILE: rtl/sba_engine.sv
// Allocation and free engine: page scan, bitmap update, address build
module sba_engine #(
   parameter int MAX_PAGES    = sba_pkg::MAX_PAGES_DEF,
   parameter int EXPAND_PAGES = sba_pkg::EXPAND_PAGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sba_pkg::cmd_type           cmd,
   input  logic                       cmd_empty,
   output logic                       cmd_pop,
   input  logic [sba_pkg::ADDR_W-1:0] page0_base,
   sba_rsp_if.source                  rsp
);
   import sba_pkg::*;

   localparam int PW     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PMW    = $clog2(MAX_PAGES + 1);
   localparam int QW     = (MAX_PAGES * EXPAND_PAGES > 1) ?
                           $clog2(MAX_PAGES * EXPAND_PAGES) : 1;
   localparam int RSH    = QW + $clog2(EXPAND_PAGES);
   localparam int PRW    = 2 * QW + 2;
   // ceil(2^RSH / EXPAND_PAGES): exact quotient for every QW-bit page offset
   localparam logic [PRW-1:0] RCP =
      PRW'(((64'd1 << RSH) + 64'(EXPAND_PAGES) - 64'd1) / 64'(EXPAND_PAGES));
   localparam int CMPW   = QW + PMW;
   localparam int POW    = $clog2(MAX_PAGES * EXPAND_PAGES + 1);
   localparam int BDEPTH = MAX_PAGES * WORDS_PER_PAGE;
   localparam int BAW    = $clog2(BDEPTH);
   localparam int MW     = $bits(meta_type);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_PAGE, S_FREAD, S_FCHK, S_FWREAD, S_FWCHK,
      S_AREAD, S_ACHK, S_WREAD, S_WCHK, S_NEW, S_CLR, S_OFFS, S_ADDR, S_RESP
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   logic [PW-1:0]          p_ff;
   logic [1:0]             w_ff;
   logic [SLOT_W-1:0]      used_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [PMW-1:0]         pages_ff;
   logic [QW-1:0]          dvd_ff;
   logic [QW-1:0]          quo_ff;
   logic [POW-1:0]         poff_ff;
   logic [PAGE_SHIFT-1:0]  lo12_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic [CLASS_W-1:0]     rsp_cls_ff;

   // memories
   logic                   meta_we;
   logic [PW-1:0]          meta_waddr;
   meta_type               meta_wdata, meta_rd;
   logic [MW-1:0]          meta_rdata;
   logic                   bm_we;
   logic [BAW-1:0]         bm_waddr;
   logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;

   // datapath helpers
   logic [PRW-1:0]         div_prod;
   logic [QW-1:0]          quo_back;
   logic [WORD_BITS-1:0]   bm_taken;
   logic [PAGE_SHIFT-1:0]  f_start, f_rel, f_mask;
   logic [SLOT_W-1:0]      f_idx;

   assign meta_rd = meta_type'(meta_rdata);

   sba_ram #(.WIDTH(MW), .DEPTH(MAX_PAGES)) u_meta (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (MW'(meta_wdata)),
      .rd_addr (p_ff),
      .rd_data (meta_rdata)
   );

   sba_ram #(.WIDTH(WORD_BITS), .DEPTH(BDEPTH)) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (bm_wdata),
      .rd_addr (BAW'({p_ff, w_ff})),
      .rd_data (bm_rdata)
   );

   assign cmd_pop = (state_ff == S_IDLE) && !cmd_empty;

   // page quotient by the slab stride in pages, by reciprocal multiply
   assign div_prod = PRW'(dvd_ff) * RCP;
   assign quo_back = QW'(quo_ff * EXPAND_PAGES);

   // slots that are taken or do not exist in this word
   assign bm_taken = bm_rdata | ~valid_mask(cmd_ff.cls, w_ff);

   // free offset decode against the page's class
   assign f_start = obj_offset(meta_rd.cls);
   assign f_rel   = cmd_ff.offset - f_start;
   assign f_mask  = (12'd16 << meta_rd.cls) - 12'd1;
   assign f_idx   = SLOT_W'(f_rel >> (4 + meta_rd.cls));

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = p_ff;
      meta_wdata = '{cls: cmd_ff.cls, used: used_ff};
      bm_we      = 1'b0;
      bm_waddr   = BAW'({p_ff, w_ff});
      bm_wdata   = bm_rdata;
      case (state_ff)
         S_WCHK: begin
            if (bm_taken != '1) begin
               bm_we           = 1'b1;
               bm_wdata        = bm_rdata | (64'd1 << lowest_zero(bm_taken));
               meta_we         = 1'b1;
               meta_wdata.used = used_ff + 1'b1;
            end
         end
         S_NEW: begin
            meta_we         = (pages_ff != PMW'(MAX_PAGES));
            meta_waddr      = PW'(pages_ff);
            meta_wdata.used = SLOT_W'(1);
         end
         S_CLR: begin
            bm_we    = 1'b1;
            bm_wdata = (w_ff == 2'd0) ? 64'd1 : 64'd0;
         end
         S_FWCHK: begin
            if (bm_rdata[slot_ff[5:0]]) begin
               bm_we           = 1'b1;
               bm_wdata        = bm_rdata & ~(64'd1 << slot_ff[5:0]);
               meta_we         = 1'b1;
               meta_wdata.used = (used_ff != '0) ? used_ff - 1'b1 : used_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pages_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff      <= cmd;
                  rsp_addr_ff <= '0;
                  rsp_cls_ff  <= cmd.cls;
                  if (cmd.status != ST_OK) begin
                     rsp_status_ff <= cmd.status;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_RESP;
                  end else if (cmd.is_free) begin
                     dvd_ff   <= cmd.page_q[QW-1:0];
                     state_ff <= S_DIV;
                  end else if (pages_ff == '0) begin
                     state_ff <= S_NEW;
                  end else begin
                     p_ff     <= PW'(pages_ff - 1'b1);
                     state_ff <= S_AREAD;
                  end
               end
            end
            S_DIV: begin
               quo_ff   <= QW'(div_prod >> RSH);
               state_ff <= S_PAGE;
            end
            S_PAGE: begin
               if (quo_back != dvd_ff || CMPW'(quo_ff) >= CMPW'(pages_ff)) begin
                  rsp_status_ff <= ST_UNKNOWN;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  p_ff     <= PW'(quo_ff);
                  state_ff <= S_FREAD;
               end
            end
            S_FREAD: state_ff <= S_FCHK;
            S_FCHK: begin
               rsp_cls_ff <= meta_rd.cls;
               cmd_ff.cls <= meta_rd.cls;
               used_ff    <= meta_rd.used;
               slot_ff    <= f_idx;
               w_ff       <= f_idx[7:6];
               if (cmd_ff.offset < f_start) begin
                  rsp_status_ff <= ST_UNDERFLOW;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else if ((f_rel & f_mask) != '0) begin
                  rsp_status_ff <= ST_MISALIGNED;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else if (f_idx >= class_cap(meta_rd.cls)) begin
                  rsp_status_ff <= ST_RANGE;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_FWREAD;
               end
            end
            S_FWREAD: state_ff <= S_FWCHK;
            S_FWCHK: begin
               rsp_status_ff <= bm_rdata[slot_ff[5:0]] ? ST_OK : ST_DOUBLE_FREE;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_RESP;
            end
            S_AREAD: state_ff <= S_ACHK;
            S_ACHK: begin
               used_ff <= meta_rd.used;
               w_ff    <= '0;
               if (meta_rd.cls == cmd_ff.cls && meta_rd.used < class_cap(cmd_ff.cls)) begin
                  state_ff <= S_WREAD;
               end else if (p_ff == '0) begin
                  state_ff <= S_NEW;
               end else begin
                  p_ff     <= p_ff - 1'b1;
                  state_ff <= S_AREAD;
               end
            end
            S_WREAD: state_ff <= S_WCHK;
            S_WCHK: begin
               if (bm_taken != '1) begin
                  slot_ff  <= {w_ff, lowest_zero(bm_taken)};
                  state_ff <= S_OFFS;
               end else begin
                  w_ff     <= w_ff + 1'b1;
                  state_ff <= S_WREAD;
               end
            end
            S_NEW: begin
               if (pages_ff == PMW'(MAX_PAGES)) begin
                  rsp_status_ff <= ST_NO_PAGES;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  p_ff     <= PW'(pages_ff);
                  pages_ff <= pages_ff + 1'b1;
                  w_ff     <= '0;
                  slot_ff  <= '0;
                  state_ff <= S_CLR;
               end
            end
            S_CLR: begin
               w_ff <= w_ff + 1'b1;
               if (w_ff == 2'd3) state_ff <= S_OFFS;
            end
            S_OFFS: begin
               poff_ff  <= POW'(p_ff * EXPAND_PAGES);
               lo12_ff  <= PAGE_SHIFT'(20'(obj_offset(cmd_ff.cls)) +
                                       (20'(slot_ff) << (4 + cmd_ff.cls)));
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               rsp_addr_ff   <= page0_base + ADDR_W'({poff_ff, lo12_ff});
               rsp_status_ff <= ST_OK;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.object_address = rsp_addr_ff;
   assign rsp.size_class     = rsp_cls_ff;
endmodule

FILE: rtl/slab_bitmap_allocator.sv
// Top level of the slab bitmap allocator
//
//  channel   | dir | handshake        | carries
//  ----------+-----+------------------+---------------------------------------------
//  req_chan  | in  | valid / ready    | mode, request_size, free_address
//  rsp_chan  | out | valid / ready    | status, object_address, size_class
//  csr_*     | in  | csr_wr_en only   | heap_start (low 12 bits dropped)
//
//  Each transaction gives exactly one response, in order.
//  Alloc: scans pages from the newest down, then the bitmap words of a fitting page;
//  a new page instead takes a metadata write plus clearing of its bitmap words.
//  Free: a reciprocal multiply gives the page index, then the page metadata and the
//  bitmap word are read; offset errors and unknown pages end early. Early errors (zero
//  size, too large, null, far pointer) are found by the front and answered from idle.
//  Requests queue two deep ahead of the engine while a response is stalled.
//  Reset is synchronous; no RAM clearing pass, bitmap words are cleared as pages are made.
module slab_bitmap_allocator #(
   parameter int MAX_PAGES    = sba_pkg::MAX_PAGES_DEF,
   parameter int EXPAND_PAGES = sba_pkg::EXPAND_PAGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   sba_req_if.sink                    req_chan,
   sba_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [sba_pkg::ADDR_W-1:0] csr_wr_data
);
   import sba_pkg::*;

   // slab page 0 sits one stride above the heap base
   localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(EXPAND_PAGES * PAGE_BYTES);
   localparam int CMD_W = $bits(cmd_type);

   logic [ADDR_W-1:0] page0_base_ff;
   cmd_type           front_cmd, engine_cmd;
   logic [CMD_W-1:0]  fifo_out;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;

   // heap base kept as its first slab page address, page aligned
   always_ff @(posedge clock) begin
      if (reset) begin
         page0_base_ff <= STRIDE;
      end else if (csr_wr_en) begin
         page0_base_ff <= {csr_wr_data[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} + STRIDE;
      end
   end

   // front: classify each request
   sba_front #(.MAX_PAGES(MAX_PAGES), .EXPAND_PAGES(EXPAND_PAGES)) u_front (
      .req        (req_chan),
      .page0_base (page0_base_ff),
      .cmd        (front_cmd),
      .cmd_push   (cmd_push),
      .cmd_full   (cmd_full)
   );

   // decoupling queue
   sba_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (CMD_W'(front_cmd)),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (fifo_out),
      .empty     (cmd_empty)
   );

   assign engine_cmd = cmd_type'(fifo_out);

   // back: page scan, bitmap and metadata updates, response register
   sba_engine #(.MAX_PAGES(MAX_PAGES), .EXPAND_PAGES(EXPAND_PAGES)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (engine_cmd),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .page0_base (page0_base_ff),
      .rsp        (rsp_chan)
   );
endmodule

FILE: rtl/sba_checker.sv
// Port-level checks of the slab allocator and their binding
`include "slab_bitmap_allocator_defines.svh"

module sba_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [47:0] rsp_object_address,
   input logic [2:0]  rsp_size_class
);
   import sba_pkg::*;

   `SBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_object_address), "response changed while stalled")
   `SBA_ASSERT_IMPLY(a_addr_only_ok, rsp_valid && rsp_status != ST_OK, rsp_object_address == '0, "address on a failed transaction")
   `SBA_ASSERT_IMPLY(a_no_class, rsp_valid && (rsp_status == ST_ZERO_SIZE || rsp_status == ST_TOO_LARGE || rsp_status == ST_UNKNOWN || rsp_status == ST_NULL), rsp_size_class == '0, "class on a classless status")
   `SBA_ASSERT_AFTER_RESET(a_reset_quiet, !rsp_valid, "response valid after reset")
endmodule

bind slab_bitmap_allocator sba_checker u_sba_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_object_address (rsp_chan.object_address),
   .rsp_size_class     (rsp_chan.size_class)
);
